// ===== sv/cte_pkg.sv =====
// Shared types and constants of the tile equaliser.
// No dependencies; imported by every module of the block.
`default_nettype none

package cte_pkg;

  // Fixed geometry and field widths
  localparam int BINS       = 256;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int TW_W       = 10;
  localparam int XR_W       = 14;
  localparam int AREA_W     = 20;
  localparam int MUL_W      = 20;
  localparam int PROD_W     = 40;
  localparam int ACC_W      = 35;
  localparam int DIV_W      = 43;
  localparam int HIST_W     = 15;
  localparam int LIMIT_W    = 21;
  localparam int EXCESS_W   = 23;
  localparam int CLIP_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [HIST_W-1:0] HIST_MAX = 15'h7FFF;
  localparam logic [DIV_W-1:0]  LEVELS   = 43'd255;

  // Command codes
  localparam logic [1:0] FUNC_ACCUM = 2'd0;
  localparam logic [1:0] FUNC_BUILD = 2'd1;
  localparam logic [1:0] FUNC_MAP   = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // Result kinds
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP   = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0]  DIM_RST  = 11'd1024;
  localparam logic [CLIP_W-1:0] CLIP_RST = 8'd40;

  typedef struct packed {
    logic [1:0]         func;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pixel_in;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [PIX_W-1:0] pixel_out;
  } out_item_t;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_TH, ST_TH2, ST_ROUTE, ST_DIVGO, ST_DIVWAIT,
    ST_ACC_TI, ST_ACC_TJ, ST_ACC_RD, ST_ACC_WR,
    ST_B_AREA, ST_B_DIVA, ST_B_QFIX, ST_B_LIM, ST_B_LIM2, ST_B_RD1, ST_B_EX, ST_B_RD2,
    ST_B_WR,
    ST_ACK,
    ST_M_CHK, ST_M_TI, ST_M_TI2, ST_M_TJ, ST_M_TJ2, ST_M_DX, ST_M_DY, ST_M_AREA,
    ST_M_W, ST_M_RD, ST_M_WT, ST_M_PM, ST_M_AC, ST_M_DEN1, ST_M_DEN2, ST_M_DIV,
    ST_M_OUT, ST_M_ZERO
  } cte_state_t;

endpackage

`default_nettype wire

// ===== sv/cte_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on cte_pkg for the operand width.
`default_nettype none

module cte_div
  import cte_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] num,
  input  wire logic [DIV_W-1:0] den,
  output logic                  done,
  output logic [DIV_W-1:0]      quo
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]     rem;
  logic [CNT_W-1:0]   cnt;
  logic               active;
  logic [DIV_W:0]     shifted;
  logic               fits;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    shifted = {rem[DIV_W-1:0], quo[DIV_W-1]};
    fits    = shifted >= {1'b0, den};
  end

  // Control: load on start, count down the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(DIV_W);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (active) begin
      rem <= fits ? (shifted - {1'b0, den}) : shifted;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== sv/cte_core.sv =====
// Sequencer, tile memories and shared multiplier of the tile equaliser.
// Depends on cte_pkg and instantiates cte_div.
`default_nettype none

module cte_core
  import cte_pkg::*;
#(
  parameter int TILES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire in_item_t          cmd,
  output logic                   busy,
  input  wire logic [DIM_W-1:0]  eff_width,
  input  wire logic [DIM_W-1:0]  eff_height,
  input  wire logic [CLIP_W-1:0] clip_factor,
  output logic                   result_valid,
  output out_item_t              result
);

  localparam int NTILE   = TILES * TILES;
  localparam int TIDX_W  = $clog2(NTILE);
  localparam int TI_W    = $clog2(TILES);
  localparam int HADDR_W = TIDX_W + PIX_W;
  localparam int DEPTH   = NTILE * BINS;

  // Reciprocals for the fixed divisions by the tile count and by 255
  localparam int TW_SH      = 16;
  localparam int TW_RECIP   = ((1 << TW_SH) + TILES - 1) / TILES;
  localparam int AREA_SH    = 27;
  localparam int AREA_RECIP = (1 << AREA_SH) / 255;
  localparam int QA_W       = PROD_W - AREA_SH;

  cte_state_t state, state_next, ret_state;

  in_item_t            cmd_q;
  logic [TW_W-1:0]     tw, th;
  logic [AREA_W-1:0]   area;
  logic [LIMIT_W-1:0]  limit;
  logic [EXCESS_W-1:0] excess;
  logic [HIST_W-1:0]   run;
  logic [TIDX_W-1:0]   btile;
  logic [PIX_W-1:0]    bin;
  logic [HADDR_W-1:0]  clr_cnt;
  logic [TI_W-1:0]     ti, tj;
  logic                ti_ok;
  logic                xe, ye;
  logic [TW_W-1:0]     dx, dy;
  logic [1:0]          k;
  logic                wzero;
  logic [ACC_W-1:0]    acc;
  logic [QA_W-1:0]     avg_bin;

  // Shared multiplier and divider
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_q;
  logic [DIV_W-1:0]    div_num, div_den, quo;
  logic                div_start, div_done;

  // Memories
  logic [HIST_W-1:0]   hist_mem [DEPTH];
  logic [HIST_W-1:0]   cum_mem  [DEPTH];
  logic [HIST_W-1:0]   hist_q, cum_q;
  logic                hist_re, hist_we, cum_re, cum_we;
  logic [HADDR_W-1:0]  hist_addr, cum_addr;
  logic [HIST_W-1:0]   hist_wdata, cum_wdata;

  // Geometry of the current item
  logic [TW_W-1:0]     hx, hy;
  logic [XR_W-1:0]     xr, yb;
  logic                x_lo, x_hi, y_lo, y_hi;
  logic                out_range;
  logic [TIDX_W-1:0]   acc_tile, map_tile;
  logic [TW_W-1:0]     wx0, wx1, wy0, wy1, wxs, wys;
  logic [HIST_W-1:0]   clipped;
  logic [HIST_W+1:0]   run_sum;
  logic [HIST_W-1:0]   run_new;
  logic [QA_W-1:0]     qa_raw, qa_fix;
  logic [AREA_W-1:0]   qa_rem;

  cte_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // Tile geometry, edge detection and weights
  always_comb begin
    hx        = tw >> 1;
    hy        = th >> 1;
    xr        = XR_W'((TILES - 1) * tw + hx);
    yb        = XR_W'((TILES - 1) * th + hy);
    x_lo      = cmd_q.col <= hx;
    y_lo      = cmd_q.row <= hy;
    x_hi      = XR_W'(cmd_q.col) >= xr;
    y_hi      = XR_W'(cmd_q.row) >= yb;
    out_range = (DIM_W'(cmd_q.col) >= eff_width) || (DIM_W'(cmd_q.row) >= eff_height);
    acc_tile  = TIDX_W'(tj * TILES + ti);
    map_tile  = TIDX_W'(tj * TILES + ti + (k[0] ? 1 : 0) + (k[1] ? TILES : 0));
    wx0       = xe ? TW_W'(1) : tw - dx;
    wx1       = xe ? '0 : dx;
    wy0       = ye ? TW_W'(1) : th - dy;
    wy1       = ye ? '0 : dy;
    wxs       = xe ? TW_W'(1) : tw;
    wys       = ye ? TW_W'(1) : th;
    clipped   = (LIMIT_W'(hist_q) > limit) ? limit[HIST_W-1:0] : hist_q;
    run_sum   = (HIST_W+2)'(run) + (HIST_W+2)'(clipped)
                + (HIST_W+2)'(excess[EXCESS_W-1:PIX_W]);
    run_new   = (run_sum > (HIST_W+2)'(HIST_MAX)) ? HIST_MAX : run_sum[HIST_W-1:0];
    // Reciprocal estimate of area / 255 is low by at most one; settle it
    qa_raw    = mul_q[PROD_W-1:AREA_SH];
    qa_rem    = area - (AREA_W'(qa_raw) << PIX_W) + AREA_W'(qa_raw);
    qa_fix    = (qa_rem >= AREA_W'(LEVELS)) ? qa_raw + 1'b1 : qa_raw;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (clr_cnt == HADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:    if (start) state_next = ST_TH;
      ST_TH:      state_next = ST_TH2;
      ST_TH2:     state_next = ST_ROUTE;
      ST_ROUTE: begin
        if (cmd_q.func == FUNC_BUILD) begin
          state_next = ST_B_AREA;
        end else if (out_range || (cmd_q.func != FUNC_ACCUM && cmd_q.func != FUNC_MAP)) begin
          state_next = ST_IDLE;
        end else if (tw == '0 || th == '0) begin
          state_next = (cmd_q.func == FUNC_MAP) ? ST_M_ZERO : ST_IDLE;
        end else begin
          state_next = (cmd_q.func == FUNC_MAP) ? ST_M_CHK : ST_DIVGO;
        end
      end
      ST_DIVGO:   state_next = ST_DIVWAIT;
      ST_DIVWAIT: if (div_done) state_next = ret_state;
      ST_ACC_TI:  state_next = ST_DIVGO;
      ST_ACC_TJ:  state_next = (ti_ok && quo < DIV_W'(TILES)) ? ST_ACC_RD : ST_IDLE;
      ST_ACC_RD:  state_next = ST_ACC_WR;
      ST_ACC_WR:  state_next = ST_IDLE;
      ST_B_AREA:  state_next = ST_B_DIVA;
      ST_B_DIVA:  state_next = ST_B_QFIX;
      ST_B_QFIX:  state_next = ST_B_LIM;
      ST_B_LIM:   state_next = ST_B_LIM2;
      ST_B_LIM2:  state_next = ST_B_RD1;
      ST_B_RD1:   state_next = ST_B_EX;
      ST_B_EX:    state_next = (bin == '1) ? ST_B_RD2 : ST_B_RD1;
      ST_B_RD2:   state_next = ST_B_WR;
      ST_B_WR: begin
        if (bin != '1)                             state_next = ST_B_RD2;
        else if (btile == TIDX_W'(NTILE - 1))      state_next = ST_ACK;
        else                                       state_next = ST_B_RD1;
      end
      ST_ACK:     state_next = ST_IDLE;
      ST_M_CHK:   state_next = ST_M_TI;
      ST_M_TI:    state_next = xe ? ST_M_TJ : ST_DIVGO;
      ST_M_TI2:   state_next = ST_M_TJ;
      ST_M_TJ:    state_next = ye ? ST_M_DX : ST_DIVGO;
      ST_M_TJ2:   state_next = ST_M_DX;
      ST_M_DX:    state_next = ST_M_DY;
      ST_M_DY:    state_next = ST_M_AREA;
      ST_M_AREA:  state_next = ST_M_W;
      ST_M_W:     state_next = ST_M_RD;
      ST_M_RD:    state_next = ST_M_WT;
      ST_M_WT:    state_next = ST_M_PM;
      ST_M_PM:    state_next = ST_M_AC;
      ST_M_AC:    state_next = (k == 2'd3) ? ST_M_DEN1 : ST_M_RD;
      ST_M_DEN1:  state_next = ST_M_DEN2;
      ST_M_DEN2:  state_next = ST_M_DIV;
      ST_M_DIV:   state_next = ST_DIVGO;
      ST_M_OUT:   state_next = ST_IDLE;
      ST_M_ZERO:  state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs: memory ports, multiplier operands, divider start
  always_comb begin
    hist_re    = 1'b0;
    hist_we    = 1'b0;
    hist_addr  = {btile, bin};
    hist_wdata = '0;
    cum_re     = 1'b0;
    cum_we     = 1'b0;
    cum_addr   = {btile, bin};
    cum_wdata  = run_new;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    busy       = state != ST_IDLE;
    case (state)
      ST_CLEAR: begin
        hist_we   = 1'b1;
        hist_addr = clr_cnt;
      end
      ST_IDLE: begin
        mul_a = MUL_W'(eff_width);
        mul_b = MUL_W'(TW_RECIP);
      end
      ST_TH: begin
        mul_a = MUL_W'(eff_height);
        mul_b = MUL_W'(TW_RECIP);
      end
      ST_DIVGO:  div_start = 1'b1;
      ST_ACC_RD: begin
        hist_re   = 1'b1;
        hist_addr = {acc_tile, cmd_q.pixel_in};
      end
      ST_ACC_WR: begin
        hist_we    = hist_q != HIST_MAX;
        hist_addr  = {acc_tile, cmd_q.pixel_in};
        hist_wdata = hist_q + 1'b1;
      end
      ST_B_AREA: begin
        mul_a = MUL_W'(tw);
        mul_b = MUL_W'(th);
      end
      ST_B_DIVA: begin
        mul_a = mul_q[MUL_W-1:0];
        mul_b = MUL_W'(AREA_RECIP);
      end
      ST_B_LIM: begin
        mul_a = MUL_W'(clip_factor);
        mul_b = MUL_W'(avg_bin);
      end
      ST_B_RD1, ST_B_RD2: hist_re = 1'b1;
      ST_B_WR: begin
        hist_we = 1'b1;
        cum_we  = 1'b1;
      end
      ST_M_DX: begin
        mul_a = MUL_W'(ti);
        mul_b = MUL_W'(tw);
      end
      ST_M_DY: begin
        mul_a = MUL_W'(tj);
        mul_b = MUL_W'(th);
      end
      ST_M_AREA: begin
        mul_a = MUL_W'(tw);
        mul_b = MUL_W'(th);
      end
      ST_M_RD: begin
        cum_re   = 1'b1;
        cum_addr = {map_tile, cmd_q.pixel_in};
      end
      ST_M_WT: begin
        mul_a = MUL_W'(k[0] ? wx1 : wx0);
        mul_b = MUL_W'(k[1] ? wy1 : wy0);
      end
      ST_M_PM: begin
        mul_a = mul_q[MUL_W-1:0];
        mul_b = MUL_W'(cum_q);
      end
      ST_M_DEN1: begin
        mul_a = MUL_W'(wxs);
        mul_b = MUL_W'(wys);
      end
      ST_M_DEN2: begin
        mul_a = mul_q[MUL_W-1:0];
        mul_b = area;
      end
      default: ;
    endcase
  end

  // State and reset-cleared control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= state == ST_ACK || state == ST_M_OUT || state == ST_M_ZERO;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    case (state)
      ST_ACK: begin
        result.result_kind <= KIND_ACK;
        result.pixel_out   <= '0;
      end
      ST_M_ZERO: begin
        result.result_kind <= KIND_PIXEL;
        result.pixel_out   <= '0;
      end
      ST_M_OUT: begin
        result.result_kind <= KIND_PIXEL;
        result.pixel_out   <= (|quo[DIV_W-1:PIX_W]) ? '1 : quo[PIX_W-1:0];
      end
      default: ;
    endcase
  end

  // Shared multiplier with registered product
  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  // Divider call: load operands and the return point
  always_ff @(posedge clk) begin
    if (state_next == ST_DIVGO && state != ST_DIVGO) begin
      case (state)
        ST_ROUTE: begin
          div_num   <= DIV_W'(cmd_q.col);
          div_den   <= DIV_W'(tw);
          ret_state <= ST_ACC_TI;
        end
        ST_ACC_TI: begin
          div_num   <= DIV_W'(cmd_q.row);
          div_den   <= DIV_W'(th);
          ret_state <= ST_ACC_TJ;
        end
        ST_M_TI: begin
          div_num   <= DIV_W'(cmd_q.col) - DIV_W'(hx);
          div_den   <= DIV_W'(tw);
          ret_state <= ST_M_TI2;
        end
        ST_M_TJ: begin
          div_num   <= DIV_W'(cmd_q.row) - DIV_W'(hy);
          div_den   <= DIV_W'(th);
          ret_state <= ST_M_TJ2;
        end
        default: begin
          div_num   <= DIV_W'({acc, 8'h00}) - DIV_W'(acc);
          div_den   <= DIV_W'(mul_q);
          ret_state <= ST_M_OUT;
        end
      endcase
    end
  end

  // Datapath registers advanced by the sequencer
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE:   if (start) cmd_q <= cmd;
      ST_TH:     tw <= mul_q[TW_SH +: TW_W];
      ST_TH2:    th <= mul_q[TW_SH +: TW_W];
      ST_ACC_TI: begin
        ti_ok <= quo < DIV_W'(TILES);
        ti    <= quo[TI_W-1:0];
      end
      ST_ACC_TJ: tj <= quo[TI_W-1:0];
      ST_B_DIVA: area <= mul_q[AREA_W-1:0];
      ST_B_QFIX: avg_bin <= qa_fix;
      ST_B_LIM2: begin
        limit  <= mul_q[LIMIT_W-1:0];
        btile  <= '0;
        bin    <= '0;
        excess <= '0;
      end
      ST_B_EX: begin
        if (LIMIT_W'(hist_q) > limit)
          excess <= excess + EXCESS_W'(LIMIT_W'(hist_q) - limit);
        bin <= bin + 1'b1;
        run <= '0;
      end
      ST_B_WR: begin
        run <= run_new;
        bin <= bin + 1'b1;
        if (bin == '1) begin
          excess <= '0;
          btile  <= btile + 1'b1;
        end
      end
      ST_M_CHK: begin
        xe <= x_lo || x_hi;
        ye <= y_lo || y_hi;
      end
      ST_M_TI:   if (xe) ti <= x_lo ? '0 : TI_W'(TILES - 1);
      ST_M_TI2:  ti <= quo[TI_W-1:0];
      ST_M_TJ:   if (ye) tj <= y_lo ? '0 : TI_W'(TILES - 1);
      ST_M_TJ2:  tj <= quo[TI_W-1:0];
      ST_M_DY:   dx <= xe ? '0 : TW_W'(PROD_W'(cmd_q.col) - mul_q - PROD_W'(hx));
      ST_M_AREA: dy <= ye ? '0 : TW_W'(PROD_W'(cmd_q.row) - mul_q - PROD_W'(hy));
      ST_M_W: begin
        area <= mul_q[AREA_W-1:0];
        k    <= '0;
        acc  <= '0;
      end
      ST_M_PM:   wzero <= mul_q == '0;
      ST_M_AC: begin
        acc <= acc + (wzero ? '0 : ACC_W'(mul_q));
        k   <= k + 1'b1;
      end
      default: ;
    endcase
  end

  // Histogram memory, registered read
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_addr] <= hist_wdata;
    if (hist_re) hist_q <= hist_mem[hist_addr];
  end

  // Cumulative table memory, registered read
  always_ff @(posedge clk) begin
    if (cum_we) cum_mem[cum_addr] <= cum_wdata;
    if (cum_re) cum_q <= cum_mem[cum_addr];
  end

  // A result beat never lasts more than one cycle
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result beat held for two cycles");

  // An accepted command makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // The divider only finishes while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVWAIT)
    else $error("divider finished outside a wait");

  // Tables are only written while histograms are being cleared alongside
  a_cum_with_clear: assert property (@(posedge clk) disable iff (rst)
    cum_we |-> (hist_we && hist_wdata == '0))
    else $error("table written without clearing its histogram bin");

endmodule

`default_nettype wire

// ===== sv/clahe_tile_equalizer_top.sv =====
// Contrast limited tile equaliser. A command is taken when start is high and
// busy is low; results come back as a one-cycle beat on result_valid and cannot
// be held off. Every command runs on one shared multiplier, which also does the
// fixed divisions by the tile count and by 255 through reciprocals; accumulates
// and maps also use one shared restoring divider (one quotient bit per cycle)
// for the tile position and the final scaling. An accumulate does two divisions
// and a read-modify-write of the histogram bin, a map does up to two divisions,
// four table reads and the final division, and a build steps through all 256
// bins of each tile over the single port of the histogram memory. After reset
// a clearing pass writes all TILES x TILES x 256 histogram bins (16384 at the
// default), with busy high.
// Depends on cte_pkg, cte_core and cte_div.
`default_nettype none

module clahe_tile_equalizer_top
  import cte_pkg::*;
#(
  parameter int TILES   = 8,
  parameter int MAX_DIM = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire in_item_t              cmd,
  output logic                       busy,
  output logic                       result_valid,
  output out_item_t                  result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CMP_W = 13;

  logic [DIM_W-1:0]  image_width, image_height;
  logic [CLIP_W-1:0] clip_factor;
  logic [DIM_W-1:0]  eff_width, eff_height;

  // Take configuration beats only between commands
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RST;
      image_height <= DIM_RST;
      clip_factor  <= CLIP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  image_width  <= cfg_data;
        CFG_HEIGHT: image_height <= cfg_data;
        CFG_CLIP:   clip_factor  <= cfg_data[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Limit the plane to the largest supported dimension
  always_comb begin
    eff_width  = (CMP_W'(image_width) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width;
    eff_height = (CMP_W'(image_height) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height;
  end

  cte_core #(
    .TILES (TILES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .eff_width    (eff_width),
    .eff_height   (eff_height),
    .clip_factor  (clip_factor),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
